FILE: src/eecc_pkg.sv
// ----------------------------------------------------------------------------
// eecc_pkg
// Shared types and constants of the edge enhancement and coring pipeline.
// ----------------------------------------------------------------------------
package eecc_pkg;

	localparam int CFG_W   = 8;
	localparam int INDEX_W = 3;
	localparam int EDGE_W  = 9;

	// register indexes of the configuration port
	typedef enum logic [INDEX_W-1:0] {
		REG_GAIN_HIGH      = 3'd0,
		REG_GAIN_MID       = 3'd1,
		REG_CORE_LOW       = 3'd2,
		REG_CORE_HIGH      = 3'd3,
		REG_LIMIT_NEGATIVE = 3'd4,
		REG_LIMIT_POSITIVE = 3'd5
	} reg_idx_t;

	localparam logic [CFG_W-1:0] GAIN_HIGH_RST      = 8'h40;
	localparam logic [CFG_W-1:0] GAIN_MID_RST       = 8'h60;
	localparam logic [CFG_W-1:0] CORE_LOW_RST       = 8'h05;
	localparam logic [CFG_W-1:0] CORE_HIGH_RST      = 8'h0f;
	localparam logic [CFG_W-1:0] LIMIT_NEGATIVE_RST = 8'h05;
	localparam logic [CFG_W-1:0] LIMIT_POSITIVE_RST = 8'hff;

	typedef struct packed {
		logic [CFG_W-1:0] gain_high;
		logic [CFG_W-1:0] gain_mid;
		logic [CFG_W-1:0] core_low;
		logic [CFG_W-1:0] core_high;
		logic [CFG_W-1:0] limit_negative;
		logic [CFG_W-1:0] limit_positive;
	} cfg_t;

	// control that travels alongside the data of a request
	typedef struct packed {
		logic valid;
		logic kill;      // non-green site in the last column, result is zero
		logic negative;  // centre below the ring average
	} ctl_t;

endpackage

FILE: src/eecc_grad.sv
// ----------------------------------------------------------------------------
// eecc_grad
// Laplacian magnitude and sign: neighbour sum over two stages, then the
// absolute difference against eight times the centre, shifted right by 3.
// ----------------------------------------------------------------------------
module eecc_grad #(
	parameter int PIXEL_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [PIXEL_BITS-1:0] center,
	input  logic [PIXEL_BITS-1:0] up_left,
	input  logic [PIXEL_BITS-1:0] up_mid,
	input  logic [PIXEL_BITS-1:0] up_right,
	input  logic [PIXEL_BITS-1:0] mid_left,
	input  logic [PIXEL_BITS-1:0] mid_right,
	input  logic [PIXEL_BITS-1:0] down_left,
	input  logic [PIXEL_BITS-1:0] down_mid,
	input  logic [PIXEL_BITS-1:0] down_right,
	input  logic                  green_site,
	input  logic                  last_column,
	output eecc_pkg::ctl_t        ctl_out,
	output logic [PIXEL_BITS-1:0] mag_out
);
	import eecc_pkg::*;

	localparam int PAIR_W = PIXEL_BITS + 1;
	localparam int SUM_W  = PIXEL_BITS + 3;

	ctl_t              ctl_s1, ctl_s2, ctl_s3;
	logic [PAIR_W-1:0] pair_s1 [4];
	logic [PIXEL_BITS-1:0] center_s1;
	logic [SUM_W-1:0]  ring_s2, centre8_s2;
	logic [PIXEL_BITS-1:0] mag_s3;

	logic              neg_d;
	logic [SUM_W-1:0]  absd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= '{valid: in_valid, kill: !green_site && last_column, negative: 1'b0};
			ctl_s2 <= ctl_s1;
			// stage 3: sign joins the control
			ctl_s3 <= '{valid: ctl_s2.valid, kill: ctl_s2.kill, negative: neg_d};
		end
	end

	always_comb begin
		neg_d = centre8_s2 < ring_s2;
		if (neg_d) begin
			absd_d = ring_s2 - centre8_s2;
		end else begin
			absd_d = centre8_s2 - ring_s2;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: pairwise neighbour sums
		pair_s1[0]      <= PAIR_W'(up_left) + PAIR_W'(up_mid);
		pair_s1[1]      <= PAIR_W'(up_right) + PAIR_W'(mid_left);
		pair_s1[2]      <= PAIR_W'(mid_right) + PAIR_W'(down_left);
		pair_s1[3]      <= PAIR_W'(down_mid) + PAIR_W'(down_right);
		center_s1       <= center;
		// stage 2: full ring sum
		ring_s2         <= (SUM_W'(pair_s1[0]) + SUM_W'(pair_s1[1]))
		                 + (SUM_W'(pair_s1[2]) + SUM_W'(pair_s1[3]));
		centre8_s2      <= {center_s1, 3'b000};
		// stage 3: sign and magnitude
		mag_s3          <= absd_d[SUM_W-1:3];
	end

	assign ctl_out = ctl_s3;
	assign mag_out = mag_s3;

endmodule

FILE: src/eecc_core.sv
// ----------------------------------------------------------------------------
// eecc_core
// Coring band selection and gain multiply.
// ----------------------------------------------------------------------------
module eecc_core #(
	parameter int PIXEL_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  eecc_pkg::cfg_t                        cfg,
	input  eecc_pkg::ctl_t                        ctl_in,
	input  logic [PIXEL_BITS-1:0]                 mag_in,
	output eecc_pkg::ctl_t                        ctl_out,
	output logic [PIXEL_BITS+eecc_pkg::CFG_W-1:0] prod_out
);
	import eecc_pkg::*;

	localparam int PROD_W = PIXEL_BITS + CFG_W;

	ctl_t                  ctl_s4, ctl_s5;
	logic [PIXEL_BITS-1:0] op_s4;
	logic [CFG_W-1:0]      gain_s4;
	logic [PROD_W-1:0]     prod_s5;

	logic [PIXEL_BITS-1:0] low_ext, high_ext, op_d;
	logic [CFG_W-1:0]      gain_d;

	assign low_ext  = PIXEL_BITS'(cfg.core_low);
	assign high_ext = PIXEL_BITS'(cfg.core_high);

	// crossed thresholds leave the mid band empty by the order of the tests
	always_comb begin
		priority if (mag_in > high_ext) begin
			op_d   = mag_in;
			gain_d = cfg.gain_high;
		end else if (mag_in > low_ext) begin
			op_d   = mag_in - low_ext;
			gain_d = cfg.gain_mid;
		end else begin
			op_d   = '0;
			gain_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= ctl_in;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s4           <= op_d;
		gain_s4         <= gain_d;
		prod_s5         <= PROD_W'(op_s4) * PROD_W'(gain_s4);
	end

	assign ctl_out  = ctl_s5;
	assign prod_out = prod_s5;

endmodule

FILE: src/eecc_clamp.sv
// ----------------------------------------------------------------------------
// eecc_clamp
// Scaling down with sign-aware floor rounding, limit clamp and output register.
// ----------------------------------------------------------------------------
module eecc_clamp #(
	parameter int PIXEL_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  eecc_pkg::cfg_t                        cfg,
	input  eecc_pkg::ctl_t                        ctl_in,
	input  logic [PIXEL_BITS+eecc_pkg::CFG_W-1:0] prod_in,
	output logic                                  done,
	output logic signed [eecc_pkg::EDGE_W-1:0]    edge_value
);
	import eecc_pkg::*;

	localparam int PROD_W = PIXEL_BITS + CFG_W;
	localparam int Q_W    = PROD_W - 4;
	localparam int M_W    = Q_W - 1;

	logic [Q_W-1:0]   q_d;
	logic [Q_W:0]     q_up_d;
	logic [M_W-1:0]   m_d;
	logic [CFG_W-1:0] lim_d, mc_d;
	logic [EDGE_W-1:0] val_d;
	logic              done_s6;
	logic [EDGE_W-1:0] edge_s6;

	always_comb begin
		q_d    = prod_in[PROD_W-1:4];
		q_up_d = (Q_W+1)'(q_d) + (Q_W+1)'(3);
		// negative side rounds towards minus infinity
		if (ctl_in.negative) begin
			m_d   = q_up_d[Q_W:2];
			lim_d = cfg.limit_negative;
		end else begin
			m_d   = M_W'(q_d[Q_W-1:2]);
			lim_d = cfg.limit_positive;
		end
		if (m_d > M_W'(lim_d)) begin
			mc_d = lim_d;
		end else begin
			mc_d = m_d[CFG_W-1:0];
		end
		if (ctl_in.kill) begin
			val_d = '0;
		end else if (ctl_in.negative) begin
			val_d = -{1'b0, mc_d};
		end else begin
			val_d = {1'b0, mc_d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		edge_s6 <= val_d;
	end

	assign done       = done_s6;
	assign edge_value = edge_s6;

endmodule

FILE: src/edge_enhance_coring_curve.sv
// ----------------------------------------------------------------------------
// edge_enhance_coring_curve
// Laplacian edge enhancement with coring curve on a green 5x5 window.
// ----------------------------------------------------------------------------
// One pixel request is taken on every clock where start is high; busy is
// always low. The result appears on edge_value with done high when the request
// has passed through the registered pipeline stages (pair sums, ring sum,
// magnitude, band select, gain multiply, round and clamp). The receiver
// cannot stall, and none is needed: the pipeline never holds. Registers may
// be written only when no request is in flight.
module edge_enhance_coring_curve #(
	parameter int PIXEL_BITS = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [PIXEL_BITS-1:0]              center,
	input  logic [PIXEL_BITS-1:0]              up_left,
	input  logic [PIXEL_BITS-1:0]              up_mid,
	input  logic [PIXEL_BITS-1:0]              up_right,
	input  logic [PIXEL_BITS-1:0]              mid_left,
	input  logic [PIXEL_BITS-1:0]              mid_right,
	input  logic [PIXEL_BITS-1:0]              down_left,
	input  logic [PIXEL_BITS-1:0]              down_mid,
	input  logic [PIXEL_BITS-1:0]              down_right,
	input  logic                               green_site,
	input  logic                               last_column,
	input  logic                               write_enable,
	input  logic [eecc_pkg::INDEX_W-1:0]       reg_index,
	input  logic [eecc_pkg::CFG_W-1:0]         write_data,
	output logic                               done,
	output logic signed [eecc_pkg::EDGE_W-1:0] edge_value
);
	import eecc_pkg::*;

	localparam int PROD_W = PIXEL_BITS + CFG_W;

	cfg_t                  cfg_q;
	ctl_t                  ctl_grad, ctl_core;
	logic [PIXEL_BITS-1:0] mag;
	logic [PROD_W-1:0]     prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_high      <= GAIN_HIGH_RST;
			cfg_q.gain_mid       <= GAIN_MID_RST;
			cfg_q.core_low       <= CORE_LOW_RST;
			cfg_q.core_high      <= CORE_HIGH_RST;
			cfg_q.limit_negative <= LIMIT_NEGATIVE_RST;
			cfg_q.limit_positive <= LIMIT_POSITIVE_RST;
		end else if (write_enable) begin
			// unknown indexes are dropped
			unique case (reg_idx_t'(reg_index))
				REG_GAIN_HIGH:      cfg_q.gain_high      <= write_data;
				REG_GAIN_MID:       cfg_q.gain_mid       <= write_data;
				REG_CORE_LOW:       cfg_q.core_low       <= write_data;
				REG_CORE_HIGH:      cfg_q.core_high      <= write_data;
				REG_LIMIT_NEGATIVE: cfg_q.limit_negative <= write_data;
				REG_LIMIT_POSITIVE: cfg_q.limit_positive <= write_data;
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	eecc_grad #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_grad (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start),
		.center     (center),
		.up_left    (up_left),
		.up_mid     (up_mid),
		.up_right   (up_right),
		.mid_left   (mid_left),
		.mid_right  (mid_right),
		.down_left  (down_left),
		.down_mid   (down_mid),
		.down_right (down_right),
		.green_site (green_site),
		.last_column(last_column),
		.ctl_out    (ctl_grad),
		.mag_out    (mag)
	);

	eecc_core #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.ctl_in  (ctl_grad),
		.mag_in  (mag),
		.ctl_out (ctl_core),
		.prod_out(prod)
	);

	eecc_clamp #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctl_in    (ctl_core),
		.prod_in   (prod),
		.done      (done),
		.edge_value(edge_value)
	);

endmodule

FILE: tb/tb_edge_enhance_coring_curve.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edge_enhance_coring_curve
// Self-checking bench for the edge enhancement and coring curve. A directed
// table covers the extremes, the coring bands, the kill case, the limits and
// the register writes, then random pixel windows run under changing register
// settings and sender gaps. Each request is predicted on acceptance and each
// result is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_edge_enhance_coring_curve;
	import eecc_pkg::*;

	localparam int PIXEL_BITS     = 10;
	localparam int PIXEL_MAX      = (1 << PIXEL_BITS) - 1;
	localparam int PIPE_LATENCY   = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 125;

	// indexes with no register behind them, writes are dropped
	localparam logic [INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] center;
		logic [PIXEL_BITS-1:0] up_left;
		logic [PIXEL_BITS-1:0] up_mid;
		logic [PIXEL_BITS-1:0] up_right;
		logic [PIXEL_BITS-1:0] mid_left;
		logic [PIXEL_BITS-1:0] mid_right;
		logic [PIXEL_BITS-1:0] down_left;
		logic [PIXEL_BITS-1:0] down_mid;
		logic [PIXEL_BITS-1:0] down_right;
		logic                  green_site;
		logic                  last_column;
	} pixel_t;

	typedef struct {
		logic signed [EDGE_W-1:0] edge_value;
		int unsigned              seq;
	} edge_expect_t;

	typedef enum bit {ROW_REQUEST, ROW_WRITE} row_kind_t;

	typedef enum int {CFG_RESET, CFG_TYPICAL, CFG_EXTREME, CFG_RANDOM} cfg_scheme_t;

	typedef struct {
		row_kind_t                kind;
		logic [INDEX_W-1:0]       index;
		logic [CFG_W-1:0]         data;
		logic [PIXEL_BITS-1:0]    centre;
		logic [PIXEL_BITS-1:0]    ring_level;
		logic                     green;
		logic                     last;
		bit                       has_known;
		logic signed [EDGE_W-1:0] known;
	} row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	pixel_t                   req;
	logic                     write_enable;
	logic [INDEX_W-1:0]       reg_index;
	logic [CFG_W-1:0]         write_data;
	logic                     done;
	logic signed [EDGE_W-1:0] edge_value;

	// expected value typed into the table, travels with the request
	logic                     known_valid;
	logic signed [EDGE_W-1:0] known_edge;

	cfg_t         cfg_shadow;
	edge_expect_t edge_expect_q [$];
	edge_expect_t head;
	int unsigned  request_count;
	int unsigned  mismatch_count;
	int unsigned  idle_cycles;

	row_t directed_rows [$] = '{
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd512, 10'd512, 1'b1, 1'b0, 1'b1, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b1, 9'sd255},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b1, -9'sd5},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd1023, 10'd0, 1'b0, 1'b1, 1'b1, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd1023, 10'd0, 1'b0, 1'b0, 1'b1, 9'sd255},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd1023, 10'd0, 1'b1, 1'b1, 1'b1, 9'sd255},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd100, 10'd95, 1'b1, 1'b0, 1'b1, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd100, 10'd90, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd115, 10'd100, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd116, 10'd100, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd90, 10'd100, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd0, 10'd0, 1'b1, 1'b0, 1'b1, 9'sd0},
		'{ROW_WRITE, REG_LIMIT_NEGATIVE, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b1, -9'sd255},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd99, 10'd100, 1'b1, 1'b0, 1'b1, 9'sd0},
		'{ROW_WRITE, REG_GAIN_HIGH, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_LIMIT_POSITIVE, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b1, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b1, -9'sd255},
		'{ROW_WRITE, REG_LIMIT_NEGATIVE, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd0, 10'd1023, 1'b1, 1'b0, 1'b1, 9'sd0},
		'{ROW_WRITE, REG_LIMIT_POSITIVE, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_LIMIT_NEGATIVE, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_CORE_LOW, 8'd200, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_CORE_HIGH, 8'd10, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd100, 10'd90, 1'b1, 1'b0, 1'b1, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd102, 10'd90, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd90, 10'd102, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_UNMAPPED_LO, 8'h00, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_UNMAPPED_HI, 8'hff, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd102, 10'd90, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_GAIN_MID, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_CORE_LOW, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_CORE_HIGH, 8'd255, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd200, 10'd190, 1'b1, 1'b0, 1'b0, 9'sd0},
		'{ROW_WRITE, REG_GAIN_HIGH, 8'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 9'sd0},
		'{ROW_REQUEST, REG_GAIN_HIGH, 8'd0, 10'd1023, 10'd0, 1'b1, 1'b0, 1'b1, 9'sd0}
	};

	cfg_scheme_t phase_scheme [6] = '{CFG_TYPICAL, CFG_EXTREME, CFG_RANDOM,
		CFG_TYPICAL, CFG_RESET, CFG_TYPICAL};
	int phase_idle_pct [6] = '{0, 51, 38, 51, 0, 38};

	edge_enhance_coring_curve #(
		.PIXEL_BITS(PIXEL_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.center(req.center),
		.up_left(req.up_left),
		.up_mid(req.up_mid),
		.up_right(req.up_right),
		.mid_left(req.mid_left),
		.mid_right(req.mid_right),
		.down_left(req.down_left),
		.down_mid(req.down_mid),
		.down_right(req.down_right),
		.green_site(req.green_site),
		.last_column(req.last_column),
		.write_enable(write_enable),
		.reg_index(reg_index),
		.write_data(write_data),
		.done(done),
		.edge_value(edge_value)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic signed [EDGE_W-1:0] predict_edge(input pixel_t p, input cfg_t c);
		int unsigned centre8;
		int unsigned ring;
		int unsigned mag;
		int unsigned cored;
		int unsigned q;
		int          val;
		bit          negative;
		if (!p.green_site && p.last_column)
			return '0;
		centre8 = int'(p.center) << 3;
		ring = 0;
		ring += p.up_left;
		ring += p.up_mid;
		ring += p.up_right;
		ring += p.mid_left;
		ring += p.mid_right;
		ring += p.down_left;
		ring += p.down_mid;
		ring += p.down_right;
		// a tie counts as a positive edge
		negative = centre8 < ring;
		mag = negative ? ring - centre8 : centre8 - ring;
		mag = mag >> 3;
		if (mag > c.core_high)
			cored = mag * c.gain_high;
		else if (mag > c.core_low)
			cored = (mag - c.core_low) * c.gain_mid;
		else
			cored = 0;
		q = cored / 16;
		// floor rounding on the negative side
		val = negative ? -int'((q + 3) >> 2) : int'(q >> 2);
		if (val > int'(c.limit_positive))
			val = int'(c.limit_positive);
		else if (val < -int'(c.limit_negative))
			val = -int'(c.limit_negative);
		return val[EDGE_W-1:0];
	endfunction

	function automatic logic [PIXEL_BITS-1:0] near_level(input int base, input int spread);
		int v;
		v = base + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		else if (v > PIXEL_MAX)
			v = PIXEL_MAX;
		return v[PIXEL_BITS-1:0];
	endfunction

	function automatic logic [PIXEL_BITS-1:0] noisy_level();
		case ($urandom_range(3))
			0: return '0;
			1: return PIXEL_MAX[PIXEL_BITS-1:0];
			default: return PIXEL_BITS'($urandom_range(PIXEL_MAX));
		endcase
	endfunction

	// mostly near-flat windows so the magnitude lands around the thresholds
	function automatic pixel_t make_pixel();
		pixel_t p;
		int     base;
		int     spread;
		if ($urandom_range(9) < 2) begin
			p.center     = noisy_level();
			p.up_left    = noisy_level();
			p.up_mid     = noisy_level();
			p.up_right   = noisy_level();
			p.mid_left   = noisy_level();
			p.mid_right  = noisy_level();
			p.down_left  = noisy_level();
			p.down_mid   = noisy_level();
			p.down_right = noisy_level();
		end else begin
			base   = $urandom_range(PIXEL_MAX);
			spread = 1 << $urandom_range(6);
			p.center     = near_level(base, spread);
			p.up_left    = near_level(base, spread);
			p.up_mid     = near_level(base, spread);
			p.up_right   = near_level(base, spread);
			p.mid_left   = near_level(base, spread);
			p.mid_right  = near_level(base, spread);
			p.down_left  = near_level(base, spread);
			p.down_mid   = near_level(base, spread);
			p.down_right = near_level(base, spread);
		end
		p.green_site  = 1'($urandom_range(1));
		p.last_column = ($urandom_range(3) == 0);
		return p;
	endfunction

	function automatic cfg_t make_cfg(input cfg_scheme_t scheme);
		cfg_t c;
		case (scheme)
			CFG_RESET: begin
				c = '{GAIN_HIGH_RST, GAIN_MID_RST, CORE_LOW_RST, CORE_HIGH_RST,
					LIMIT_NEGATIVE_RST, LIMIT_POSITIVE_RST};
			end
			CFG_TYPICAL: begin
				c.gain_high      = CFG_W'($urandom_range(255));
				c.gain_mid       = CFG_W'($urandom_range(255));
				c.core_low       = CFG_W'($urandom_range(31));
				c.core_high      = c.core_low + CFG_W'($urandom_range(63));
				c.limit_negative = CFG_W'($urandom_range(255));
				c.limit_positive = CFG_W'($urandom_range(255));
			end
			CFG_EXTREME: begin
				c = '0;
				c.gain_high      = $urandom_range(1) ? 8'hff : 8'h00;
				c.gain_mid       = $urandom_range(1) ? 8'hff : 8'h00;
				c.core_low       = $urandom_range(1) ? 8'hff : 8'h00;
				c.core_high      = $urandom_range(1) ? 8'hff : 8'h00;
				c.limit_negative = $urandom_range(1) ? 8'hff : 8'h00;
				c.limit_positive = $urandom_range(1) ? 8'hff : 8'h00;
			end
			default: begin
				c = 48'({$urandom, $urandom});
				c.gain_high = CFG_W'($urandom_range(255));
			end
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_pixel(input pixel_t p, input bit has_known,
			input logic signed [EDGE_W-1:0] known, input int idle_pct);
		int gap;
		gap = 0;
		while (int'($urandom_range(99)) < idle_pct && gap < 16)
			gap++;
		write_enable <= 1'b0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		req         <= p;
		known_valid <= has_known;
		known_edge  <= known;
		do
			@(posedge clk);
		while (busy);
	endtask

	// hold the sender off until every outstanding request has produced its result
	task automatic wait_for_results();
		start        <= 1'b0;
		write_enable <= 1'b0;
		@(posedge clk);
		while (edge_expect_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [INDEX_W-1:0] index, input logic [CFG_W-1:0] data);
		write_enable <= 1'b1;
		reg_index    <= index;
		write_data   <= data;
		@(posedge clk);
	endtask

	// prediction on acceptance, checking of results, watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_shadow  = '{GAIN_HIGH_RST, GAIN_MID_RST, CORE_LOW_RST, CORE_HIGH_RST,
				LIMIT_NEGATIVE_RST, LIMIT_POSITIVE_RST};
			idle_cycles = 0;
		end else begin
			if (done) begin
				if (edge_expect_q.size() == 0) begin
					report_mismatch($sformatf("result %0d with no request outstanding",
						edge_value));
				end else begin
					head = edge_expect_q.pop_front();
					if (edge_value !== head.edge_value)
						report_mismatch($sformatf("request %0d edge_value %0d, expected %0d",
							head.seq, edge_value, head.edge_value));
				end
			end
			if (start && !busy) begin
				edge_expect_q.push_back('{known_valid ? known_edge : predict_edge(req, cfg_shadow),
					request_count});
				request_count++;
			end
			if (write_enable) begin
				case (reg_index)
					REG_GAIN_HIGH:      cfg_shadow.gain_high      = write_data;
					REG_GAIN_MID:       cfg_shadow.gain_mid       = write_data;
					REG_CORE_LOW:       cfg_shadow.core_low       = write_data;
					REG_CORE_HIGH:      cfg_shadow.core_high      = write_data;
					REG_LIMIT_NEGATIVE: cfg_shadow.limit_negative = write_data;
					REG_LIMIT_POSITIVE: cfg_shadow.limit_positive = write_data;
					default: ;
				endcase
			end
			if ((start && !busy) || done || write_enable)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", edge_expect_q.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		pixel_t p;
		cfg_t   c;
		int     pct;
		arst_n         = 1'b0;
		start          = 1'b0;
		req            = '0;
		write_enable   = 1'b0;
		reg_index      = REG_GAIN_HIGH;
		write_data     = '0;
		known_valid    = 1'b0;
		known_edge     = '0;
		request_count  = 0;
		mismatch_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_for_results();
				write_register(directed_rows[i].index, directed_rows[i].data);
			end else begin
				p.center      = directed_rows[i].centre;
				p.up_left     = directed_rows[i].ring_level;
				p.up_mid      = directed_rows[i].ring_level;
				p.up_right    = directed_rows[i].ring_level;
				p.mid_left    = directed_rows[i].ring_level;
				p.mid_right   = directed_rows[i].ring_level;
				p.down_left   = directed_rows[i].ring_level;
				p.down_mid    = directed_rows[i].ring_level;
				p.down_right  = directed_rows[i].ring_level;
				p.green_site  = directed_rows[i].green;
				p.last_column = directed_rows[i].last;
				send_pixel(p, directed_rows[i].has_known, directed_rows[i].known, 0);
			end
		end

		foreach (phase_scheme[ph]) begin
			wait_for_results();
			c = make_cfg(phase_scheme[ph]);
			write_register(REG_GAIN_HIGH, c.gain_high);
			write_register(REG_GAIN_MID, c.gain_mid);
			write_register(REG_CORE_LOW, c.core_low);
			write_register(REG_CORE_HIGH, c.core_high);
			write_register(REG_LIMIT_NEGATIVE, c.limit_negative);
			write_register(REG_LIMIT_POSITIVE, c.limit_positive);
			write_register($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
				CFG_W'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// every third stretch of twenty requests runs back to back
				pct = ((n / 20) % 3 == 2) ? 0 : phase_idle_pct[ph];
				send_pixel(make_pixel(), 1'b0, '0, pct);
			end
		end

		wait_for_results();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
